// File: rtl/ntps_pkg.sv
// ----------------------------------------------------------------------------
// ntps_pkg
// Shared types and constants of the nearest track point search unit.
// ----------------------------------------------------------------------------
package ntps_pkg;

  // fixed field widths of the stream items
  localparam int OP_W    = 1;
  localparam int INDEX_W = 10;
  localparam int COORD_W = 16;
  localparam int COUNT_W = 11;
  localparam int DIST_W  = 33;

  localparam int S_TDATA_W = 48;  // point_index, coord_x, coord_y, zero fill
  localparam int M_TDATA_W = 64;  // nearest, previous, following, distance, zero fill

  // input tdata layout
  localparam int S_INDEX_LSB = 0;
  localparam int S_X_LSB     = S_INDEX_LSB + INDEX_W;
  localparam int S_Y_LSB     = S_X_LSB + COORD_W;
  localparam int S_USED_W    = S_Y_LSB + COORD_W;

  // output tdata layout
  localparam int M_NEAREST_LSB   = 0;
  localparam int M_PREVIOUS_LSB  = M_NEAREST_LSB + INDEX_W;
  localparam int M_FOLLOWING_LSB = M_PREVIOUS_LSB + INDEX_W;
  localparam int M_DIST_LSB      = M_FOLLOWING_LSB + INDEX_W;
  localparam int M_USED_W        = M_DIST_LSB + DIST_W;

  // operation codes carried in s_tuser
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_POINT_COUNT = 1'b0;  // word index paddr[2]
  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 11'd1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

// File: rtl/ntps_ram.sv
// ----------------------------------------------------------------------------
// ntps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ntps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/nearest_track_point_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_track_point_search_unit
// Operation: a load is written to the point RAM when accepted; a query reads
// the active point count of points from the point RAM, one point read per cycle,
// through a three-stage distance pipe, then returns its result.
// Throughput: one load per cycle while idle; a new query is taken only after the previous result is registered.
// Reset: synchronous, clears control and point_count (to 1); points are
// undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_track_point_search_unit #(
  parameter int MAX_POINTS  = 1024,
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ntps_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ntps_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ntps_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [9:0] point_index, [25:10] coord_x, [41:26] coord_y, [47:42] zero
  input  logic [ntps_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] op
  input  logic [ntps_pkg::OP_W-1:0]          s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [9:0] nearest_index, [19:10] previous_index, [29:20] following_index,
  // [62:30] least_distance_sq, [63] zero
  output logic [ntps_pkg::M_TDATA_W-1:0]     m_tdata
);
  import ntps_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = 2 * COORD_WIDTH + 1;
  localparam int CMP_W  = (SUM_W > 64) ? 64 : SUM_W;

  // ---------------- configuration ----------------
  logic [COUNT_W-1:0] point_count;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RESET;
    end else if (cfg_write && paddr[2] == REG_POINT_COUNT) begin
      point_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_POINT_COUNT) ?
                  APB_DATA_W'(point_count) : '0;

  // clamp to 1..MAX_POINTS
  logic [CNT_W-1:0] active_count;
  always_comb begin
    priority if (point_count == '0) begin
      active_count = CNT_W'(1);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      active_count = CNT_W'(MAX_POINTS);
    end else begin
      active_count = CNT_W'(point_count);
    end
  end

  // ---------------- input fields ----------------
  logic        [INDEX_W-1:0]     in_index;
  logic signed [COORD_W-1:0]     in_x_raw, in_y_raw;
  logic signed [COORD_WIDTH-1:0] in_x, in_y;
  logic                          in_xfer;

  assign in_index = s_tdata[S_INDEX_LSB +: INDEX_W];
  assign in_x_raw = s_tdata[S_X_LSB +: COORD_W];
  assign in_y_raw = s_tdata[S_Y_LSB +: COORD_W];
  assign in_x     = COORD_WIDTH'(in_x_raw);
  assign in_y     = COORD_WIDTH'(in_y_raw);
  assign in_xfer  = s_tvalid && s_tready;

  // ---------------- control ----------------
  state_t state;
  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_m1;
  logic signed [COORD_WIDTH-1:0] qx, qy;

  logic              v1, v2, v3;
  logic [IDX_W-1:0]  idx1, idx2, idx3;
  logic              pipe_empty;
  logic              out_free;
  logic              issue;
  logic              finish;

  assign s_tready   = (state == ST_IDLE);
  assign cnt_m1     = cnt - CNT_W'(1);
  assign issue      = (state == ST_SCAN);
  assign pipe_empty = !v1 && !v2 && !v3;
  assign out_free   = !m_tvalid || m_tready;
  assign finish     = (state == ST_FLUSH) && pipe_empty && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && s_tuser == OP_QUERY) begin
            state    <= ST_SCAN;
            scan_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (CNT_W'(scan_idx) == cnt_m1) begin
            state <= ST_FLUSH;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tuser == OP_QUERY) begin
      qx  <= in_x;
      qy  <= in_y;
      cnt <= active_count;
    end
  end

  // ---------------- point RAM ----------------
  logic                       ram_we;
  logic [2*COORD_WIDTH-1:0]   ram_rdata;
  logic signed [COORD_WIDTH-1:0] rx, ry;

  assign ram_we = in_xfer && s_tuser == OP_LOAD &&
                  32'(in_index) < 32'(MAX_POINTS);

  ntps_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_index)),
    .wdata ({in_y, in_x}),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  assign rx = ram_rdata[COORD_WIDTH-1:0];
  assign ry = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];

  // ---------------- distance pipe ----------------
  logic signed [COORD_WIDTH:0] diff_x, diff_y, abs_x, abs_y;
  logic [COORD_WIDTH-1:0]      dx, dy;
  logic [2*COORD_WIDTH-1:0]    sq_x, sq_y;
  logic [SUM_W-1:0]            sum;
  logic                        sat;
  logic [CMP_W-1:0]            cur_dist;
  logic [CMP_W-1:0]            best_d;
  logic [IDX_W-1:0]            best_idx;
  logic                        best_found;

  always_comb begin
    diff_x   = $signed({rx[COORD_WIDTH-1], rx}) - $signed({qx[COORD_WIDTH-1], qx});
    diff_y   = $signed({ry[COORD_WIDTH-1], ry}) - $signed({qy[COORD_WIDTH-1], qy});
    abs_x    = diff_x[COORD_WIDTH] ? -diff_x : diff_x;
    abs_y    = diff_y[COORD_WIDTH] ? -diff_y : diff_y;
    sum      = SUM_W'(sq_x) + SUM_W'(sq_y);
    sat      = (SUM_W > 64) ? sum[SUM_W-1] : 1'b0;
    cur_dist = sat ? '1 : CMP_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= scan_idx;
    idx2 <= idx1;
    idx3 <= idx2;
    dx   <= abs_x[COORD_WIDTH-1:0];
    dy   <= abs_y[COORD_WIDTH-1:0];
    sq_x <= dx * dx;
    sq_y <= dy * dy;
  end

  // strict less-than in index order keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (in_xfer && s_tuser == OP_QUERY) begin
      best_found <= 1'b0;
    end else if (v3 && (!best_found || cur_dist < best_d)) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (!best_found || cur_dist < best_d)) begin
      best_d   <= cur_dist;
      best_idx <= idx3;
    end
  end

  // ---------------- result register ----------------
  logic [IDX_W-1:0] prev_idx, next_idx;

  always_comb begin
    prev_idx = (best_idx == '0) ? IDX_W'(cnt_m1) : best_idx - IDX_W'(1);
    next_idx = (CNT_W'(best_idx) == cnt_m1) ? '0 : best_idx + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= M_TDATA_W'({DIST_W'(best_d), INDEX_W'(next_idx),
                             INDEX_W'(prev_idx), INDEX_W'(best_idx)});
    end
  end

endmodule

// File: rtl/ntps_checker.sv
// ----------------------------------------------------------------------------
// ntps_checker
// Port-level checks of the nearest track point search unit.
// ----------------------------------------------------------------------------
module ntps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [ntps_pkg::OP_W-1:0]      s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ntps_pkg::M_TDATA_W-1:0] m_tdata
);
  import ntps_pkg::*;

  logic [INDEX_W-1:0] near_i, prev_i, foll_i;
  assign near_i = m_tdata[M_NEAREST_LSB +: INDEX_W];
  assign prev_i = m_tdata[M_PREVIOUS_LSB +: INDEX_W];
  assign foll_i = m_tdata[M_FOLLOWING_LSB +: INDEX_W];

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a query transfer starts a scan, no new item next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
    else $error("input taken during scan");

  // a load leaves the input ready in the next cycle
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_LOAD |=> s_tready)
    else $error("load stalled the input");

  // ring neighbours follow the nearest index or wrap
  a_ring: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (foll_i == near_i + INDEX_W'(1) || foll_i == '0) &&
                 (prev_i == near_i - INDEX_W'(1) || near_i == '0))
    else $error("ring neighbours inconsistent");

endmodule

bind nearest_track_point_search_unit ntps_checker u_ntps_checker (.*);
